### hw/rtl/csr_pkg.sv
// Shared types and constants for the context symbol rewrite block.
package csr_pkg;

  localparam int unsigned ContextMax  = 2;
  localparam int unsigned WindowDepth = 5;

  // per-cell equality flags against the configured context symbols
  typedef struct packed {
    logic tgt;
    logic bnear;
    logic bfar;
    logic anear;
    logic afar;
  } cell_eq_t;

endpackage

### hw/rtl/csr_cell.sv
// One window cell: holds a symbol, passes it on, compares it with the context.
module csr_cell import csr_pkg::*; #(
  parameter int unsigned SYMBOL_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [SYMBOL_BITS-1:0] sym_i,
  input  logic [SYMBOL_BITS-1:0] target_i,
  input  logic [SYMBOL_BITS-1:0] before_near_i,
  input  logic [SYMBOL_BITS-1:0] before_far_i,
  input  logic [SYMBOL_BITS-1:0] after_near_i,
  input  logic [SYMBOL_BITS-1:0] after_far_i,
  output logic [SYMBOL_BITS-1:0] sym_o,
  output cell_eq_t               eq_o
);

  logic [SYMBOL_BITS-1:0] sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
    end else if (shift_i) begin
      sym_q <= sym_i;
    end
  end

  assign sym_o       = sym_q;
  assign eq_o.tgt    = (sym_q == target_i);
  assign eq_o.bnear  = (sym_q == before_near_i);
  assign eq_o.bfar   = (sym_q == before_far_i);
  assign eq_o.anear  = (sym_q == after_near_i);
  assign eq_o.afar   = (sym_q == after_far_i);

endmodule

### hw/rtl/csr_outbuf.sv
// Two-entry result buffer between the decision stage and the output stream.
module csr_outbuf #(
  parameter int unsigned DATA_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hw/rtl/context_symbol_rewrite.sv
// Top level of the context symbol rewrite block.
//
// Symbols enter on the s_axis stream (tdata: in_symbol; tlast ends a sequence)
// and leave on m_axis (tdata: out_symbol; tuser: out_replaced; tlast: end).
// A target symbol whose before/after context matches is replaced by the
// substitute. Registers are written on the cfg channel (index 0..7), always
// ready; the user must write them only while the block is idle, which the
// block itself does not enforce. A row of five cells holds the newest symbols
// and shifts once per accepted transaction; a decision stage reads the
// registered row and pushes the result into a two-entry output buffer.
// Inputs are registered in the cell row, results in the output buffer.
// Throughput: one symbol per cycle while m_axis is not stalled. A
// transaction with tlast yields up to after_count+1 results, one per cycle
// while the buffer has room, and input is held off while they drain.
// Reset clears the registers, the cells, the sequence count and the buffer.
// When the receiver stalls the buffer fills and s_axis_tready drops; nothing
// is lost.
module context_symbol_rewrite import csr_pkg::*; #(
  parameter int unsigned SYMBOL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SYMBOL_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [SYMBOL_BITS-1:0] in_symbol
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SYMBOL_BITS+7)/8)*8-1:0]    m_axis_tdata,   // [SYMBOL_BITS-1:0] out_symbol
  output logic                                m_axis_tuser,   // [0] out_replaced
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [SYMBOL_BITS-1:0]              cfg_data_i
);

  localparam int unsigned TdataW = ((SYMBOL_BITS + 7) / 8) * 8;
  localparam int unsigned ResW   = SYMBOL_BITS + 2;

  typedef enum logic [2:0] {
    RegTarget     = 3'd0,
    RegSubstitute = 3'd1,
    RegBeforeCnt  = 3'd2,
    RegAfterCnt   = 3'd3,
    RegBeforeNear = 3'd4,
    RegBeforeFar  = 3'd5,
    RegAfterNear  = 3'd6,
    RegAfterFar   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       emit;
    logic       ctx;
    logic [1:0] off;
  } event_t;

  function automatic logic [1:0] clamp_count(input logic [1:0] v);
    return (v == 2'd3) ? 2'(ContextMax) : v;
  endfunction

  // configuration
  logic [SYMBOL_BITS-1:0] target_q, subst_q, bnear_q, bfar_q, anear_q, afar_q;
  logic [1:0]             bcnt_q, acnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      subst_q  <= '0;
      bcnt_q   <= '0;
      acnt_q   <= '0;
      bnear_q  <= '0;
      bfar_q   <= '0;
      anear_q  <= '0;
      afar_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegTarget:     target_q <= cfg_data_i;
        RegSubstitute: subst_q  <= cfg_data_i;
        RegBeforeCnt:  bcnt_q   <= clamp_count(cfg_data_i[1:0]);
        RegAfterCnt:   acnt_q   <= clamp_count(cfg_data_i[1:0]);
        RegBeforeNear: bnear_q  <= cfg_data_i;
        RegBeforeFar:  bfar_q   <= cfg_data_i;
        RegAfterNear:  anear_q  <= cfg_data_i;
        RegAfterFar:   afar_q   <= cfg_data_i;
      endcase
    end
  end

  // cell row
  logic                   in_acc;
  logic [SYMBOL_BITS-1:0] cell_in [WindowDepth];
  logic [SYMBOL_BITS-1:0] win     [WindowDepth];
  cell_eq_t               eq      [WindowDepth];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < WindowDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = s_axis_tdata[SYMBOL_BITS-1:0];
    end else begin : g_link
      assign cell_in[k] = win[k-1];
    end
    csr_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (in_acc),
      .sym_i        (cell_in[k]),
      .target_i     (target_q),
      .before_near_i(bnear_q),
      .before_far_i (bfar_q),
      .after_near_i (anear_q),
      .after_far_i  (afar_q),
      .sym_o        (win[k]),
      .eq_o         (eq[k])
    );
  end

  // sequence position and event capture
  logic [2:0] seen_q, seen_inc, seen_m1, a3, b3;
  event_t     ev_q;
  logic       buf_full, push, retire;

  assign a3       = {1'b0, acnt_q};
  assign b3       = {1'b0, bcnt_q};
  assign seen_inc = (seen_q == 3'd7) ? seen_q : seen_q + 3'd1;
  assign seen_m1  = seen_inc - 3'd1;

  assign push   = ev_q.valid && ev_q.emit && !buf_full;
  assign retire = ev_q.valid && (!ev_q.emit || !buf_full) &&
                  (!ev_q.last || ev_q.off == 2'd0);
  assign s_axis_tready = !ev_q.valid || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      ev_q   <= '0;
    end else if (in_acc) begin
      seen_q     <= s_axis_tlast ? 3'd0 : seen_inc;
      ev_q.valid <= 1'b1;
      ev_q.last  <= s_axis_tlast;
      ev_q.emit  <= s_axis_tlast || (seen_inc >= a3 + 3'd1);
      ev_q.ctx   <= (seen_inc >= a3 + b3 + 3'd1);
      ev_q.off   <= (s_axis_tlast && seen_m1 <= a3) ? seen_m1[1:0] : acnt_q;
    end else if (retire) begin
      ev_q.valid <= 1'b0;
    end else if (push) begin
      ev_q.off <= ev_q.off - 2'd1;
    end
  end

  // decision
  logic                   t_ok, bn_ok, bf_ok, an_ok, af_ok, rep, res_last;
  logic [SYMBOL_BITS-1:0] sel_sym, res_sym;

  always_comb begin
    unique case (acnt_q)
      2'd0: begin
        t_ok  = eq[0].tgt;
        an_ok = 1'b1;
        af_ok = 1'b1;
        bn_ok = eq[1].bnear;
        bf_ok = eq[2].bfar;
      end
      2'd1: begin
        t_ok  = eq[1].tgt;
        an_ok = eq[0].anear;
        af_ok = 1'b1;
        bn_ok = eq[2].bnear;
        bf_ok = eq[3].bfar;
      end
      default: begin
        t_ok  = eq[2].tgt;
        an_ok = eq[1].anear;
        af_ok = eq[0].afar;
        bn_ok = eq[3].bnear;
        bf_ok = eq[4].bfar;
      end
    endcase
    unique case (ev_q.off)
      2'd0:    sel_sym = win[0];
      2'd1:    sel_sym = win[1];
      default: sel_sym = win[2];
    endcase
  end

  assign rep = ev_q.ctx && (ev_q.off == acnt_q) && t_ok && an_ok && af_ok &&
               (bcnt_q == 2'd0 || bn_ok) && (bcnt_q < 2'd2 || bf_ok);
  assign res_sym  = rep ? subst_q : sel_sym;
  assign res_last = ev_q.last && (ev_q.off == 2'd0);

  // output buffer
  logic [ResW-1:0] buf_data;

  csr_outbuf #(.DATA_W(ResW)) u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({res_last, rep, res_sym}),
    .full_o     (buf_full),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (buf_data)
  );

  assign m_axis_tdata = TdataW'(buf_data[SYMBOL_BITS-1:0]);
  assign m_axis_tuser = buf_data[SYMBOL_BITS];
  assign m_axis_tlast = buf_data[SYMBOL_BITS+1];

endmodule
